[rtl/pdps_pkg.sv]
// ----------------------------------------------------------------------------
// pdps_pkg
// Shared types, register indexes and constant tables for the posterize,
// ordered dither and palette snap pipeline.
// ----------------------------------------------------------------------------
package pdps_pkg;

  typedef logic [255:0][7:0] rom256_t;
  typedef logic [31:0][19:0] recip_tab_t;
  typedef logic [16:0][63:0] root_tab_t;

  typedef enum logic [2:0] {
    CFG_LEVEL_COUNT     = 3'd0,
    CFG_PALETTE_SELECT  = 3'd1,
    CFG_DITHER_STRENGTH = 3'd2,
    CFG_MIX_AMOUNT      = 3'd3,
    CFG_IMAGE_HEIGHT    = 3'd4
  } cfg_index_t;

  typedef enum logic [2:0] {
    PAL_OFF   = 3'd0,
    PAL_CGA   = 3'd1,
    PAL_EGA   = 3'd2,
    PAL_NES   = 3'd3,
    PAL_PICO8 = 3'd4,
    PAL_C64   = 3'd5,
    PAL_GB    = 3'd6
  } pal_sel_t;

  localparam int unsigned RECIP_SHIFT = 20;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } side_t;

  typedef struct packed {
    logic [2:0][7:0] rgb;
    logic [3:0]      best;
    logic [19:0]     bestd;
  } srch_t;

  function automatic logic [3:0] bayer(input logic [3:0] pos);
    case (pos)
      4'd0:  bayer = 4'd0;
      4'd1:  bayer = 4'd8;
      4'd2:  bayer = 4'd2;
      4'd3:  bayer = 4'd10;
      4'd4:  bayer = 4'd12;
      4'd5:  bayer = 4'd4;
      4'd6:  bayer = 4'd14;
      4'd7:  bayer = 4'd6;
      4'd8:  bayer = 4'd3;
      4'd9:  bayer = 4'd11;
      4'd10: bayer = 4'd1;
      4'd11: bayer = 4'd9;
      4'd12: bayer = 4'd15;
      4'd13: bayer = 4'd7;
      4'd14: bayer = 4'd13;
      default: bayer = 4'd5;
    endcase
  endfunction

  function automatic logic [4:0] pal_count(input logic [2:0] sel);
    case (sel)
      PAL_CGA:   pal_count = 5'd4;
      PAL_EGA:   pal_count = 5'd16;
      PAL_NES:   pal_count = 5'd8;
      PAL_PICO8: pal_count = 5'd16;
      PAL_C64:   pal_count = 5'd8;
      PAL_GB:    pal_count = 5'd4;
      default:   pal_count = 5'd0;
    endcase
  endfunction

  // Entry as {r, g, b}; unused slots read black.
  function automatic logic [23:0] pal_rgb(input logic [2:0] sel, input logic [3:0] i);
    logic [23:0] c;
    c = 24'h000000;
    case (sel)
      PAL_CGA: begin
        case (i)
          4'd1: c = {8'd85, 8'd255, 8'd255};
          4'd2: c = {8'd255, 8'd85, 8'd255};
          4'd3: c = {8'd255, 8'd255, 8'd255};
          default: c = 24'h000000;
        endcase
      end
      PAL_EGA: begin
        case (i)
          4'd1:  c = {8'd0, 8'd0, 8'd170};
          4'd2:  c = {8'd0, 8'd170, 8'd0};
          4'd3:  c = {8'd0, 8'd170, 8'd170};
          4'd4:  c = {8'd170, 8'd0, 8'd0};
          4'd5:  c = {8'd170, 8'd0, 8'd170};
          4'd6:  c = {8'd170, 8'd85, 8'd0};
          4'd7:  c = {8'd170, 8'd170, 8'd170};
          4'd8:  c = {8'd85, 8'd85, 8'd85};
          4'd9:  c = {8'd85, 8'd85, 8'd255};
          4'd10: c = {8'd85, 8'd255, 8'd85};
          4'd11: c = {8'd85, 8'd255, 8'd255};
          4'd12: c = {8'd255, 8'd85, 8'd85};
          4'd13: c = {8'd255, 8'd85, 8'd255};
          4'd14: c = {8'd255, 8'd255, 8'd85};
          4'd15: c = {8'd255, 8'd255, 8'd255};
          default: c = 24'h000000;
        endcase
      end
      PAL_NES: begin
        case (i)
          4'd1: c = {8'd124, 8'd124, 8'd124};
          4'd2: c = {8'd188, 8'd188, 8'd188};
          4'd3: c = {8'd252, 8'd252, 8'd252};
          4'd4: c = {8'd0, 8'd88, 8'd248};
          4'd5: c = {8'd248, 8'd56, 8'd0};
          4'd6: c = {8'd88, 8'd216, 8'd84};
          4'd7: c = {8'd248, 8'd152, 8'd248};
          default: c = 24'h000000;
        endcase
      end
      PAL_PICO8: begin
        case (i)
          4'd1:  c = {8'd29, 8'd43, 8'd83};
          4'd2:  c = {8'd126, 8'd37, 8'd83};
          4'd3:  c = {8'd0, 8'd135, 8'd81};
          4'd4:  c = {8'd171, 8'd82, 8'd54};
          4'd5:  c = {8'd95, 8'd87, 8'd79};
          4'd6:  c = {8'd194, 8'd195, 8'd199};
          4'd7:  c = {8'd255, 8'd241, 8'd232};
          4'd8:  c = {8'd255, 8'd0, 8'd77};
          4'd9:  c = {8'd255, 8'd163, 8'd0};
          4'd10: c = {8'd255, 8'd236, 8'd39};
          4'd11: c = {8'd0, 8'd228, 8'd54};
          4'd12: c = {8'd41, 8'd173, 8'd255};
          4'd13: c = {8'd131, 8'd118, 8'd156};
          4'd14: c = {8'd255, 8'd119, 8'd168};
          4'd15: c = {8'd255, 8'd204, 8'd170};
          default: c = 24'h000000;
        endcase
      end
      PAL_C64: begin
        case (i)
          4'd1: c = {8'd255, 8'd255, 8'd255};
          4'd2: c = {8'd136, 8'd57, 8'd50};
          4'd3: c = {8'd103, 8'd182, 8'd189};
          4'd4: c = {8'd139, 8'd63, 8'd150};
          4'd5: c = {8'd85, 8'd160, 8'd73};
          4'd6: c = {8'd64, 8'd49, 8'd141};
          4'd7: c = {8'd191, 8'd206, 8'd114};
          default: c = 24'h000000;
        endcase
      end
      PAL_GB: begin
        case (i)
          4'd0: c = {8'd15, 8'd56, 8'd15};
          4'd1: c = {8'd48, 8'd98, 8'd48};
          4'd2: c = {8'd139, 8'd172, 8'd15};
          4'd3: c = {8'd155, 8'd188, 8'd15};
          default: c = 24'h000000;
        endcase
      end
      default: c = 24'h000000;
    endcase
    pal_rgb = c;
  endfunction

  // Elaboration-time helpers below: shift-subtract divide, integer root, log2 and power.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] rm;
    q  = '0;
    rm = '0;
    for (int i = 63; i >= 0; i--) begin
      rm = {rm[62:0], n[i]};
      if (rm >= d) begin
        rm   = rm - d;
        q[i] = 1'b1;
      end
    end
    udiv64 = q;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    n = n_in;
    r = '0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    isqrt64 = r;
  endfunction

  function automatic logic [63:0] log2_q16(input logic [63:0] x);
    logic [63:0] e;
    logic [63:0] m;
    logic [63:0] frac;
    e    = '0;
    frac = '0;
    while ((x >> (e + 1)) != 0) e = e + 1;
    m = x << (30 - e);
    for (int i = 0; i < 16; i++) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m    = m >> 1;
        frac = frac | 64'd1;
      end
    end
    log2_q16 = (e << 16) | frac;
  endfunction

  function automatic logic [7:0] pow_entry(input logic [63:0] x, input logic [63:0] num,
                                           input logic [63:0] den, input root_tab_t roots);
    logic [63:0] a;
    logic [63:0] ip;
    logic [63:0] h;
    logic [63:0] val;
    if (x == 0) return 8'd0;
    if (x >= 255) return 8'd255;
    a   = log2_q16(64'd255) - log2_q16(x);
    a   = udiv64(a * num + (den >> 1), den);
    ip  = a >> 16;
    h   = 64'd65536 - (a & 64'hFFFF);
    val = 64'd1 << 30;
    if (h == 64'd65536) begin
      if (ip > 40) return 8'd0;
      val = val >> ip;
    end else begin
      for (int i = 1; i <= 16; i++)
        if (((h >> (16 - i)) & 64'd1) != 0) val = (val * roots[i]) >> 30;
      if (ip + 1 > 40) return 8'd0;
      val = val >> (ip + 1);
    end
    val = (64'd255 * val + (64'd1 << 29)) >> 30;
    return (val > 255) ? 8'd255 : val[7:0];
  endfunction

  // inverse=0 gives the forward curve, inverse=1 the inverse curve.
  function automatic rom256_t build_gamma_rom(input int gamma_milli, input logic inverse);
    rom256_t   rom;
    root_tab_t roots;
    logic [63:0] g;
    g = (gamma_milli < 10) ? 64'd10 : 64'(gamma_milli);
    roots[0] = 64'd2 << 30;
    for (int i = 1; i <= 16; i++) roots[i] = isqrt64(roots[i-1] << 30);
    for (int x = 0; x < 256; x++) begin
      if (inverse) rom[x] = pow_entry(64'(x), 64'd1000, g, roots);
      else         rom[x] = pow_entry(64'(x), g, 64'd1000, roots);
    end
    build_gamma_rom = rom;
  endfunction

  // ceil(2^RECIP_SHIFT / (2*lm1)), exact for dividends below 2^14.
  function automatic recip_tab_t build_recip();
    recip_tab_t t;
    logic [63:0] d;
    logic [63:0] q;
    t[0] = '0;
    for (int k = 1; k < 32; k++) begin
      d    = 64'(2 * k);
      q    = udiv64((64'd1 << RECIP_SHIFT) + d - 64'd1, d);
      t[k] = q[19:0];
    end
    build_recip = t;
  endfunction

endpackage

[rtl/posterize_dither_palette_snap.sv]
// ----------------------------------------------------------------------------
// posterize_dither_palette_snap
// Gamma, ordered-dither posterize, optional palette snap and mix, one RGBA
// pixel per clock.
// ----------------------------------------------------------------------------
// Usage: drive a pixel with start high; it is taken at any edge where busy
// is low, and busy never rises, so a pixel can enter every clock. Each beat
// carries RGBA plus column and row (row counted from the bottom edge).
// Results leave in order on the out_ ports, one per accepted pixel, with
// out_valid high for exactly one cycle; the receiver cannot hold them off.
// The pixel passes 24 register stages; out_valid and the out_ ports are
// registered together in the last one. Throughput is one pixel per cycle.
// The depth is set by the 16-stage palette search, one palette entry
// compared per stage, behind a 6-stage front end (gamma ROM, numerator,
// divide by 8160, rounding dividend, divide by reciprocal, inverse ROM)
// and ahead of a select stage and a mix stage.
// Configuration: cfg_we with cfg_index and cfg_data writes one register;
// write only while no pixel is in flight. Reset (rst_n low, synchronous)
// restores register defaults and empties the pipeline.
// ----------------------------------------------------------------------------
module posterize_dither_palette_snap
  import pdps_pkg::*;
#(
  parameter int GAMMA_MILLI = 1000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  input  logic [7:0]  in_alpha_in,
  input  logic [11:0] in_column,
  input  logic [11:0] in_row,
  output logic        out_valid,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic [7:0]  out_alpha_out,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam rom256_t    FWD_ROM = build_gamma_rom(GAMMA_MILLI, 1'b0);
  localparam rom256_t    INV_ROM = build_gamma_rom(GAMMA_MILLI, 1'b1);
  localparam recip_tab_t RECIP   = build_recip();
  localparam int         LAST    = 23;

  // configuration registers
  logic [5:0]  level_count_r;
  logic [2:0]  palette_select_r;
  logic [7:0]  dither_strength_r;
  logic [8:0]  mix_amount_r;
  logic [12:0] image_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_count_r     <= 6'd5;
      palette_select_r  <= 3'd0;
      dither_strength_r <= 8'd77;
      mix_amount_r      <= 9'd256;
      image_height_r    <= 13'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LEVEL_COUNT:     level_count_r     <= cfg_data[5:0];
        CFG_PALETTE_SELECT:  palette_select_r  <= cfg_data[2:0];
        CFG_DITHER_STRENGTH: dither_strength_r <= cfg_data[7:0];
        CFG_MIX_AMOUNT:      mix_amount_r      <= cfg_data[8:0];
        CFG_IMAGE_HEIGHT:    image_height_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [4:0]  lm1;
  logic [19:0] recip;
  logic [8:0]  mix_sat;
  logic        pal_on;
  logic [4:0]  pal_cnt;

  always_comb begin
    if (level_count_r < 6'd2)       lm1 = 5'd1;
    else if (level_count_r > 6'd32) lm1 = 5'd31;
    else                            lm1 = 5'(level_count_r - 6'd1);
    recip   = RECIP[lm1];
    mix_sat = (mix_amount_r > 9'd256) ? 9'd256 : mix_amount_r;
    pal_on  = (palette_select_r >= PAL_CGA) && (palette_select_r <= PAL_GB);
    pal_cnt = pal_count(palette_select_r);
  end

  logic in_fire;
  assign busy    = 1'b0;
  assign in_fire = start && !busy;

  // valid bits and pass-through source pixel
  logic  v_r    [1:LAST];
  side_t side_r [1:LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= LAST; k++) v_r[k] <= 1'b0;
    end else begin
      v_r[1] <= in_fire;
      for (int k = 2; k <= LAST; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    side_r[1] <= '{r: in_red_in, g: in_green_in, b: in_blue_in, a: in_alpha_in};
    for (int k = 2; k <= LAST; k++) side_r[k] <= side_r[k-1];
  end

  // stage 1: forward gamma, dither offset
  logic [1:0]         ty;
  logic [3:0]         bay;
  logic signed [5:0]  bay_term;
  logic signed [12:0] off_nxt;
  logic [2:0][7:0]    g1_nxt;
  logic [2:0][7:0]    g1_r;
  logic signed [12:0] off1_r;

  always_comb begin
    ty       = 2'(image_height_r[1:0] - 2'd1 - in_row[1:0]);
    bay      = bayer({ty, in_column[1:0]});
    bay_term = $signed({1'b0, bay, 1'b0}) - 6'sd15;
    off_nxt  = 13'($signed({1'b0, dither_strength_r}) * bay_term);
    g1_nxt[0] = FWD_ROM[in_red_in];
    g1_nxt[1] = FWD_ROM[in_green_in];
    g1_nxt[2] = FWD_ROM[in_blue_in];
  end

  always_ff @(posedge clk) begin
    g1_r   <= g1_nxt;
    off1_r <= off_nxt;
  end

  // stage 2: numerator of the level index
  logic [2:0][17:0] num_nxt;
  logic [2:0][17:0] num2_r;

  always_comb begin
    logic [12:0]        gl;
    logic signed [19:0] sum;
    for (int c = 0; c < 3; c++) begin
      gl  = 13'(g1_r[c]) * 13'(lm1);
      sum = $signed({2'b00, gl, 5'b00000}) + 20'sd4080 + 20'(off1_r);
      num_nxt[c] = sum[17:0];
    end
  end

  always_ff @(posedge clk) num2_r <= num_nxt;

  // stage 3: divide by 8160 (estimate by 8192, one correction), clamp
  logic [2:0][4:0] idx_nxt;
  logic [2:0][4:0] idx3_r;

  always_comb begin
    logic [4:0]  qe;
    logic [17:0] rem;
    logic [5:0]  q6;
    for (int c = 0; c < 3; c++) begin
      qe  = num2_r[c][17:13];
      rem = num2_r[c] - 18'(18'(qe) * 18'd8160);
      q6  = {1'b0, qe} + ((rem >= 18'd8160) ? 6'd1 : 6'd0);
      idx_nxt[c] = (q6 > {1'b0, lm1}) ? lm1 : q6[4:0];
    end
  end

  always_ff @(posedge clk) idx3_r <= idx_nxt;

  // stage 4: rounding dividend idx*510 + lm1
  logic [2:0][13:0] n4_r;

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++)
      n4_r[c] <= 14'(14'(idx3_r[c]) * 14'd510) + 14'(lm1);
  end

  // stage 5: divide by 2*lm1 through the reciprocal
  logic [2:0][7:0] r5_r;

  always_ff @(posedge clk) begin
    logic [33:0] prod;
    for (int c = 0; c < 3; c++) begin
      prod     = 34'(n4_r[c]) * 34'(recip);
      r5_r[c] <= prod[RECIP_SHIFT +: 8];
    end
  end

  // stage 6: inverse gamma, seed the palette search
  srch_t srch_r [6:22];

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) srch_r[6].rgb[c] <= INV_ROM[r5_r[c]];
    srch_r[6].best  <= 4'd0;
    srch_r[6].bestd <= '1;
  end

  // stages 7..22: one palette entry per stage, strict less-than keeps first
  for (genvar j = 0; j < 16; j++) begin : g_srch
    srch_t srch_nxt;

    always_comb begin
      logic [23:0]       ink;
      logic signed [8:0] dr, dg, db;
      logic [15:0]       sr, sg, sb;
      logic [19:0]       wdist;
      ink  = pal_rgb(palette_select_r, 4'(j));
      dr   = $signed({1'b0, srch_r[6+j].rgb[0]}) - $signed({1'b0, ink[23:16]});
      dg   = $signed({1'b0, srch_r[6+j].rgb[1]}) - $signed({1'b0, ink[15:8]});
      db   = $signed({1'b0, srch_r[6+j].rgb[2]}) - $signed({1'b0, ink[7:0]});
      sr   = 16'(dr * dr);
      sg   = 16'(dg * dg);
      sb   = 16'(db * db);
      wdist = 20'(sr) * 20'd6 + 20'(sg) * 20'd5 + 20'(sb) * 20'd4;
      srch_nxt = srch_r[6+j];
      if ((5'(j) < pal_cnt) && (wdist < srch_r[6+j].bestd)) begin
        srch_nxt.best  = 4'(j);
        srch_nxt.bestd = wdist;
      end
    end

    always_ff @(posedge clk) srch_r[7+j] <= srch_nxt;
  end

  // stage 23: take the winning entry, or the searched colour when no palette is on
  logic [2:0][7:0] sel23_r;

  always_ff @(posedge clk) begin
    logic [23:0] ink;
    ink = pal_rgb(palette_select_r, srch_r[22].best);
    if (pal_on) sel23_r <= {ink[7:0], ink[15:8], ink[23:16]};
    else        sel23_r <= srch_r[22].rgb;
  end

  // stage 24: blend with the source pixel
  logic [2:0][7:0] src23;
  logic [2:0][7:0] mix_nxt;

  always_comb begin
    logic [16:0] acc;
    src23 = {side_r[LAST].b, side_r[LAST].g, side_r[LAST].r};
    for (int c = 0; c < 3; c++) begin
      acc = 17'(17'(src23[c]) * 17'(9'd256 - mix_sat)) + 17'(17'(sel23_r[c]) * 17'(mix_sat))
            + 17'd128;
      mix_nxt[c] = acc[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= v_r[LAST];
  end

  always_ff @(posedge clk) begin
    out_red_out   <= mix_nxt[0];
    out_green_out <= mix_nxt[1];
    out_blue_out  <= mix_nxt[2];
    out_alpha_out <= side_r[LAST].a;
  end

  a_out_follows_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(v_r[LAST]))
    else $error("result strobe without an item at the last stage");

  a_pipe_advances: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] |=> v_r[2])
    else $error("pipeline dropped a beat");

  a_idx_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[3] |-> (idx3_r[0] <= lm1) && (idx3_r[1] <= lm1) && (idx3_r[2] <= lm1))
    else $error("level index above level count");

  a_best_in_palette: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[22] && pal_on) |-> (5'(srch_r[22].best) < pal_cnt))
    else $error("palette winner beyond palette size");

endmodule
